### src/md5bh_pkg.sv
// Package for the MD5 block hash: word types, chaining initial values,
// round constant table, message index schedule and rotate amounts.
// No dependencies.
`default_nettype none

package md5bh_pkg;

   typedef logic [31:0] word_type;
   typedef logic [5:0]  round_type;
   typedef logic [3:0]  index_type;
   typedef logic [4:0]  shift_type;
   typedef logic [1:0]  phase_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } abcd_type;

   localparam word_type INIT_A = 32'h67452301;
   localparam word_type INIT_B = 32'hefcdab89;
   localparam word_type INIT_C = 32'h98badcfe;
   localparam word_type INIT_D = 32'h10325476;

   localparam abcd_type INIT_CHAIN = '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};

   localparam phase_type PHASE_F = 2'd0;
   localparam phase_type PHASE_G = 2'd1;
   localparam phase_type PHASE_H = 2'd2;
   localparam phase_type PHASE_I = 2'd3;

   localparam round_type LAST_ROUND = 6'd63;
   localparam index_type LAST_POS   = 4'd15;

   localparam word_type K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   function automatic index_type msg_index(input round_type rnd);
      index_type lo;
      index_type idx;
      lo = rnd[3:0];
      unique case (phase_type'(rnd[5:4]))
         PHASE_F: idx = lo;
         PHASE_G: idx = index_type'({lo, 2'b00}) + lo + index_type'(1);
         PHASE_H: idx = index_type'({lo, 1'b0}) + lo + index_type'(5);
         PHASE_I: idx = index_type'({lo, 3'b000}) - lo;
         default: idx = lo;
      endcase
      return idx;
   endfunction

   function automatic shift_type rot_amount(input round_type rnd);
      shift_type s;
      unique case ({rnd[5:4], rnd[1:0]})
         4'd0:  s = 5'd7;
         4'd1:  s = 5'd12;
         4'd2:  s = 5'd17;
         4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;
         4'd5:  s = 5'd9;
         4'd6:  s = 5'd14;
         4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;
         4'd9:  s = 5'd11;
         4'd10: s = 5'd16;
         4'd11: s = 5'd23;
         4'd12: s = 5'd6;
         4'd13: s = 5'd10;
         4'd14: s = 5'd15;
         4'd15: s = 5'd21;
         default: s = 5'd7;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

### src/md5bh_chan_if.sv
// Valid/ready channel interfaces for message words and digest results.
// Depends on md5bh_pkg.
`default_nettype none

interface md5bh_req_if
   import md5bh_pkg::*;
   ();
   logic     valid;
   logic     ready;
   word_type message_word;
   logic     last_of_message;

   modport source (output valid, output message_word, output last_of_message, input ready);
   modport sink   (input valid, input message_word, input last_of_message, output ready);
endinterface

interface md5bh_rsp_if
   import md5bh_pkg::*;
   ();
   logic     valid;
   logic     ready;
   word_type digest_a;
   word_type digest_b;
   word_type digest_c;
   word_type digest_d;

   modport source (output valid, output digest_a, output digest_b, output digest_c,
                   output digest_d, input ready);
   modport sink   (input valid, input digest_a, input digest_b, input digest_c,
                   input digest_d, output ready);
endinterface

`default_nettype wire

### src/md5bh_msg_store.sv
// Sixteen-entry block word store: one write port, one registered read port.
// Depends on md5bh_pkg.
`default_nettype none

module md5bh_msg_store
   import md5bh_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      wr_en,
   input  wire index_type wr_addr,
   input  wire word_type  wr_data,
   input  wire index_type rd_addr,
   output      word_type  rd_data
);

   word_type mem [16];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/md5bh_round.sv
// Shared MD5 round unit: one round step on the working words per use.
// Takes the pre-added constant plus message word. Depends on md5bh_pkg.
`default_nettype none

module md5bh_round
   import md5bh_pkg::*;
(
   input  wire round_type rnd,
   input  wire abcd_type  cur,
   input  wire word_type  km,
   output      abcd_type  nxt
);

   word_type    f;
   word_type    sum;
   word_type    rot;
   logic [63:0] dbl;

   always_comb begin
      unique case (phase_type'(rnd[5:4]))
         PHASE_F: f = (cur.b & cur.c) | (~cur.b & cur.d);
         PHASE_G: f = (cur.d & cur.b) | (~cur.d & cur.c);
         PHASE_H: f = cur.b ^ cur.c ^ cur.d;
         PHASE_I: f = cur.c ^ (cur.b | ~cur.d);
         default: f = cur.b ^ cur.c ^ cur.d;
      endcase
      sum = cur.a + f + km;
      dbl = {sum, sum} << rot_amount(rnd);
      rot = dbl[63:32];
      nxt.a = cur.d;
      nxt.b = cur.b + rot;
      nxt.c = cur.b;
      nxt.d = cur.c;
   end

endmodule

`default_nettype wire

### src/md5_block_hash.sv
// MD5 block hash top level: word intake, round sequencer, chaining words.
// Depends on md5bh_pkg, md5bh_chan_if, md5bh_msg_store, md5bh_round.
//
// Usage:
//   req_chan carries the padded message, one 32-bit little-endian word per
//   handshake, sixteen words per 512-bit block. last_of_message marks the
//   final word of the final block and is ignored on any other word.
//   rsp_chan carries the digest (A..D chaining words) once per message.
// Timing:
//   Words 0..14 of a block are taken one per cycle. After word 15 the block
//   is busy: store read and constant add in PREP0 and PREP1, 64 rounds on
//   the single round unit in RUN, then a fold into the chain in FINAL.
//   The digest register is loaded from the chain sum in FINAL.
// Reset:
//   Clears the word position, loads the initial chaining values and drops
//   any pending digest.
// Stall:
//   A pending digest is held in an output register until taken; word intake
//   continues until the next final block, which waits in FINAL with intake closed.
`default_nettype none

module md5_block_hash
   import md5bh_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   md5bh_req_if.sink   req_chan,
   md5bh_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      IDLE,
      PREP0,
      PREP1,
      RUN,
      FINAL
   } state_type;

   state_type state_ff;
   index_type pos_ff;
   logic      last_ff;
   round_type fch_ff;
   round_type rnd_ff;
   word_type  km_ff;
   abcd_type  work_ff;
   abcd_type  chain_ff;
   abcd_type  digest_ff;
   logic      rsp_valid_ff;

   logic      accept;
   logic      load_digest;
   word_type  rd_data;
   abcd_type  round_out;
   abcd_type  chain_sum;
   word_type  km_in;

   assign req_chan.ready = (state_ff == IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   md5bh_msg_store u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos_ff),
      .wr_data (req_chan.message_word),
      .rd_addr (msg_index(fch_ff)),
      .rd_data (rd_data)
   );

   md5bh_round u_round (
      .rnd (rnd_ff),
      .cur (work_ff),
      .km  (km_ff),
      .nxt (round_out)
   );

   always_comb begin
      km_in       = rd_data + K_TABLE[round_type'(fch_ff - round_type'(1))];
      chain_sum.a = chain_ff.a + work_ff.a;
      chain_sum.b = chain_ff.b + work_ff.b;
      chain_sum.c = chain_ff.c + work_ff.c;
      chain_sum.d = chain_ff.d + work_ff.d;
      load_digest = (state_ff == FINAL) && last_ff && (!rsp_valid_ff || rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         pos_ff       <= '0;
         chain_ff     <= INIT_CHAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_digest) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  pos_ff <= pos_ff + index_type'(1);
                  if (pos_ff == LAST_POS) begin
                     last_ff  <= req_chan.last_of_message;
                     fch_ff   <= '0;
                     state_ff <= PREP0;
                  end
               end
            end
            PREP0: begin
               fch_ff   <= fch_ff + round_type'(1);
               state_ff <= PREP1;
            end
            PREP1: begin
               fch_ff   <= fch_ff + round_type'(1);
               km_ff    <= km_in;
               work_ff  <= chain_ff;
               rnd_ff   <= '0;
               state_ff <= RUN;
            end
            RUN: begin
               fch_ff  <= fch_ff + round_type'(1);
               km_ff   <= km_in;
               work_ff <= round_out;
               rnd_ff  <= rnd_ff + round_type'(1);
               if (rnd_ff == LAST_ROUND) begin
                  state_ff <= FINAL;
               end
            end
            FINAL: begin
               if (!last_ff) begin
                  chain_ff <= chain_sum;
                  state_ff <= IDLE;
               end else if (load_digest) begin
                  digest_ff <= chain_sum;
                  chain_ff  <= INIT_CHAIN;
                  state_ff  <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.digest_a = digest_ff.a;
   assign rsp_chan.digest_b = digest_ff.b;
   assign rsp_chan.digest_c = digest_ff.c;
   assign rsp_chan.digest_d = digest_ff.d;

endmodule

`default_nettype wire

### src/md5bh_check.sv
// Port-level checker for md5_block_hash, attached by bind.
// Depends on md5bh_pkg and the top level's channel ports.
`default_nettype none

module md5bh_check
   import md5bh_pkg::*;
(
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     req_valid,
   input wire logic     req_ready,
   input wire logic     rsp_valid,
   input wire logic     rsp_ready,
   input wire word_type digest_a,
   input wire word_type digest_d
);

   a_reset_drops_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("digest valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(digest_a) && $stable(digest_d))
      else $error("stalled digest changed");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready) && !$past(req_ready, 2))
      else $error("digest raised without a compression pass");

   a_no_intake_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("intake closed without a word taken");

endmodule

bind md5_block_hash md5bh_check u_md5bh_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .digest_a  (rsp_chan.digest_a),
   .digest_d  (rsp_chan.digest_d)
);

`default_nettype wire

### bench/md5_block_hash_tb.sv
// Testbench for md5_block_hash: drives block-aligned message words, predicts each digest
// with a local MD5 compression model and checks every digest field by field.
// Depends on md5bh_pkg, md5bh_chan_if and the md5_block_hash RTL.
`timescale 1ns / 100ps

module md5_block_hash_tb;
   import md5bh_pkg::*;

   typedef struct packed {
      word_type data;
      logic     last;
   } msg_word_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY
   } stall_mode_type;

   localparam int RANDOM_WORDS  = 1500;
   localparam int MIN_DIGESTS   = 50;
   localparam int HOLD_CYCLES   = 3000;
   localparam int IDLE_LIMIT    = 20000;
   localparam int DRAIN_CYCLES  = 100;

   localparam abcd_type CHAIN_IV = '{a: 32'h67452301, b: 32'hefcdab89,
                                     c: 32'h98badcfe, d: 32'h10325476};

   word_type round_k [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   int unsigned rot_by [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                4, 11, 16, 23, 6, 10, 15, 21};

   logic clock;
   logic reset;

   md5bh_req_if req_bus ();
   md5bh_rsp_if rsp_bus ();

   md5_block_hash u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   msg_word_type pending_words [$];
   abcd_type     digest_queue  [$];

   word_type  md5_block [16];
   abcd_type  md5_chain;
   logic [3:0] md5_pos;

   int words_taken;
   int blocks_done;
   int stray_flags;
   int digests_checked;
   int mismatches;
   int messages_queued;

   int burst_left;
   int gap_left;
   int hold_left;
   int holds_done;
   int mode_left;
   int pattern_cnt;
   int idle_cycles;
   stall_mode_type stall_mode;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string field, input word_type got, input word_type want);
      $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $time);
      mismatches++;
   endtask

   task automatic compress_block();
      word_type a, b, c, d, f, sum;
      int unsigned g, phase, rot;
      a = md5_chain.a;
      b = md5_chain.b;
      c = md5_chain.c;
      d = md5_chain.d;
      for (int r = 0; r < 64; r++) begin
         phase = r / 16;
         case (phase)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = 5 * r + 1;
            end
            2: begin
               f = b ^ c ^ d;
               g = 3 * r + 5;
            end
            default: begin
               f = c ^ (b | ~d);
               g = 7 * r;
            end
         endcase
         sum = a + f + round_k[r] + md5_block[g % 16];
         rot = rot_by[phase * 4 + (r % 4)];
         a = d;
         d = c;
         c = b;
         b = b + ((sum << rot) | (sum >> (32 - rot)));
      end
      md5_chain.a = md5_chain.a + a;
      md5_chain.b = md5_chain.b + b;
      md5_chain.c = md5_chain.c + c;
      md5_chain.d = md5_chain.d + d;
   endtask

   task automatic absorb_word(input word_type data, input logic last);
      md5_block[md5_pos] = data;
      if (md5_pos == 4'd15) begin
         compress_block();
         blocks_done++;
         if (last) begin
            digest_queue.push_back(md5_chain);
            md5_chain = CHAIN_IV;
         end
      end else if (last) begin
         stray_flags++;
      end
      md5_pos = md5_pos + 4'd1;
   endtask

   task automatic check_digest(input abcd_type got);
      abcd_type want;
      if (digest_queue.size() == 0) begin
         report_mismatch("unexpected digest_a", got.a, '0);
         return;
      end
      want = digest_queue.pop_front();
      if (got.a !== want.a) report_mismatch("digest_a", got.a, want.a);
      if (got.b !== want.b) report_mismatch("digest_b", got.b, want.b);
      if (got.c !== want.c) report_mismatch("digest_c", got.c, want.c);
      if (got.d !== want.d) report_mismatch("digest_d", got.d, want.d);
      digests_checked++;
   endtask

   function automatic word_type pick_word(input int style);
      word_type w;
      case (style)
         0: w = $urandom;
         1: w = ($urandom_range(0, 3) == 0) ? $urandom : '0;
         2: begin
            case ($urandom_range(0, 3))
               0: w = '0;
               1: w = '1;
               2: w = word_type'(1) << $urandom_range(0, 31);
               default: w = ~(word_type'(1) << $urandom_range(0, 31));
            endcase
         end
         default: w = {8'($urandom_range(0, 255)), 8'h00, 8'h80, 8'h00} ^
                      $urandom_range(0, 255);
      endcase
      return w;
   endfunction

   task automatic queue_message(input int blocks);
      msg_word_type item;
      int style;
      bit strays;
      style  = $urandom_range(0, 3);
      strays = ($urandom_range(0, 3) == 0);
      for (int blk = 0; blk < blocks; blk++) begin
         for (int pos = 0; pos < 16; pos++) begin
            item.data = pick_word(style);
            if (pos == 15)
               item.last = (blk == blocks - 1);
            else
               item.last = strays && ($urandom_range(0, 5) == 0);
            pending_words.push_back(item);
         end
      end
      messages_queued++;
   endtask

   // stimulus and end of run
   initial begin
      msg_word_type item;
      int roll;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.message_word = '0;
      req_bus.last_of_message = 1'b0;
      rsp_bus.ready = 1'b0;
      md5_chain = CHAIN_IV;
      md5_pos = '0;
      words_taken = 0;
      blocks_done = 0;
      stray_flags = 0;
      digests_checked = 0;
      mismatches = 0;
      messages_queued = 0;
      burst_left = 1;
      gap_left = 0;
      hold_left = 0;
      holds_done = 0;
      mode_left = 0;
      pattern_cnt = 0;
      idle_cycles = 0;
      stall_mode = STALL_NONE;

      // extremes, stray last flag on an inner word, digest on the final word
      for (int pos = 0; pos < 16; pos++) begin
         case (pos)
            0: item.data = 32'h00000000;
            1: item.data = 32'hffffffff;
            2: item.data = 32'h00000080;
            3: item.data = 32'h80000000;
            default: item.data = (pos % 2) ? 32'hffffffff : 32'h00000001;
         endcase
         item.last = (pos == 4) || (pos == 15);
         pending_words.push_back(item);
      end
      messages_queued++;

      while (pending_words.size() < RANDOM_WORDS + 16 || messages_queued < MIN_DIGESTS) begin
         roll = $urandom_range(0, 9);
         if (roll < 5)
            queue_message(1);
         else if (roll < 8)
            queue_message(2);
         else if (roll < 9)
            queue_message(3);
         else
            queue_message($urandom_range(4, 8));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_bus.valid) @(posedge clock);
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d message words in %0d blocks, %0d stray last flags ignored",
               words_taken, blocks_done, stray_flags);
      $display("%0d digests compared, %0d mismatches, %0d long receiver hold-offs",
               digests_checked, mismatches, holds_done);
      if (mismatches == 0 && digest_queue.size() == 0) begin
         $display("PASS md5_block_hash");
      end else begin
         $display("FAIL md5_block_hash");
      end
      $finish;
   end

   // word driver: bursts of random length with random gaps
   always @(posedge clock) begin : req_driver
      msg_word_type nxt;
      logic offer;
      nxt = '0;
      offer = 1'b0;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.message_word <= '0;
         req_bus.last_of_message <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            absorb_word(req_bus.message_word, req_bus.last_of_message);
            words_taken++;
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() > 0) begin
               nxt = pending_words.pop_front();
               offer = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 48);
                  case ($urandom_range(0, 3))
                     0: gap_left = 0;
                     1: gap_left = $urandom_range(10, 60);
                     default: gap_left = $urandom_range(1, 3);
                  endcase
               end else begin
                  burst_left--;
               end
            end
            req_bus.valid <= offer;
            req_bus.message_word <= nxt.data;
            req_bus.last_of_message <= nxt.last;
         end
      end
   end

   // digest monitor and receiver stall pattern
   always @(posedge clock) begin : rsp_monitor
      logic take;
      take = 1'b1;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_digest('{a: rsp_bus.digest_a, b: rsp_bus.digest_b,
                           c: rsp_bus.digest_c, d: rsp_bus.digest_d});
         pattern_cnt++;
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if ((holds_done == 0 && digests_checked >= 6) ||
                      (holds_done == 1 && digests_checked >= 30)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            take = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 300);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:    take = 1'b1;
               STALL_RANDOM:  take = ($urandom_range(0, 9) < 7);
               STALL_PATTERN: take = ((pattern_cnt % 7) < 3);
               default:       take = ($urandom_range(0, 9) < 2);
            endcase
         end
         rsp_bus.ready <= take;
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin : idle_watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles at %0t", idle_cycles, $time);
         $display("FAIL md5_block_hash");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

### sim.f
src/md5bh_pkg.sv
src/md5bh_chan_if.sv
src/md5bh_msg_store.sv
src/md5bh_round.sv
src/md5_block_hash.sv
src/md5bh_check.sv
bench/md5_block_hash_tb.sv
